/* src/class_aware_box_nms_defines.svh */
// Assertion macros shared by the suppression block.
// No dependencies; included by canms_back, the module that carries checks.
`ifndef CLASS_AWARE_BOX_NMS_DEFINES_SVH
`define CLASS_AWARE_BOX_NMS_DEFINES_SVH
`ifndef SYNTH
`define CANMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CANMS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CANMS_ASSERT(lbl, clk, rstn, prop, msg)
`define CANMS_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* src/canms_pkg.sv */
// Types and constants for the class-aware box suppression block.
// No dependencies.
package canms_pkg;

  localparam int unsigned MAX_BOXES_DEF = 64;
  localparam int unsigned RESULT_LIMIT  = 64;
  localparam int unsigned KW            = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned THR_W         = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;
  localparam logic [0:0] ADDR_IOU_THR   = 1'b0;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic [6:0]  cls;
    logic [13:0] anchor;
  } entry_t;

  typedef struct packed {
    entry_t box;
    logic   last_box;
  } item_t;

  typedef struct packed {
    entry_t box;
    logic   last;
    logic   ovf;
  } res_t;

endpackage

/* src/class_aware_box_nms.sv */
// Top level of the class-aware greedy box suppression block.
// Depends on canms_pkg, canms_front and canms_back.
//
//  port group  | dir | handshake            | content
//  in_*        | in  | in_valid_i/in_ready_o | one box request
//  kept_*      | out | out_valid_o/out_ready_i | one kept box
//  p*          | in  | psel/penable/pwrite  | iou_threshold at address 0
//
// Loading a box walks down from the tail past every stored box of lower score,
// moving each up one slot, until a stored box of higher or equal score ends the
// walk, then writes the new box; the input queue lies ahead of that.
// A box marked last starts the suppression pass: each kept box is tested
// against its later boxes through the four-stage overlap pipeline.
// Reset clears counts and flags; the store needs no clearing pass.
// A result waits in the output register; the engine stalls only when one is
// still held there while the next is ready.
module class_aware_box_nms #(
  parameter int unsigned MaxBoxes = canms_pkg::MAX_BOXES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] x_center_i,
  input  logic [15:0] y_center_i,
  input  logic [15:0] box_width_i,
  input  logic [15:0] box_height_i,
  input  logic [15:0] confidence_i,
  input  logic [6:0]  class_id_i,
  input  logic [13:0] anchor_index_i,
  input  logic        final_box_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] kept_x_center_o,
  output logic [15:0] kept_y_center_o,
  output logic [15:0] kept_width_o,
  output logic [15:0] kept_height_o,
  output logic [15:0] kept_score_o,
  output logic [6:0]  kept_class_o,
  output logic [13:0] kept_anchor_o,
  output logic        last_kept_o,
  output logic        overflowed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [canms_pkg::THR_W-1:0] thr_q;
  canms_pkg::item_t in_item, q_item;
  canms_pkg::res_t  res;
  logic             q_valid, q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == canms_pkg::ADDR_IOU_THR) ?
                  {{(32 - canms_pkg::THR_W){1'b0}}, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= canms_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == canms_pkg::ADDR_IOU_THR)) begin
      thr_q <= pwdata[canms_pkg::THR_W-1:0];
    end
  end

  assign in_item = '{box: '{x: x_center_i, y: y_center_i, w: box_width_i,
                            h: box_height_i, score: confidence_i,
                            cls: class_id_i, anchor: anchor_index_i},
                     last_box: final_box_i};

  canms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  canms_back #(.MaxBoxes(MaxBoxes)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign kept_x_center_o = res.box.x;
  assign kept_y_center_o = res.box.y;
  assign kept_width_o    = res.box.w;
  assign kept_height_o   = res.box.h;
  assign kept_score_o    = res.box.score;
  assign kept_class_o    = res.box.cls;
  assign kept_anchor_o   = res.box.anchor;
  assign last_kept_o     = res.last;
  assign overflowed_o    = res.ovf;

endmodule

/* src/canms_front.sv */
// Input side: two-entry request queue ahead of the engine.
// Depends on canms_pkg.
module canms_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  canms_pkg::item_t in_item_i,
  output logic             q_valid_o,
  output canms_pkg::item_t q_item_o,
  input  logic             q_pop_i
);

  canms_pkg::item_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i & q_valid_o;
  assign q_item_o   = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_item_i;
    end
  end

endmodule

/* src/canms_iou.sv */
// Four-stage overlap test of one candidate box against the current kept box.
// Depends on canms_pkg.
module canms_iou #(
  parameter int unsigned AW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [canms_pkg::THR_W-1:0]  thr_i,
  input  canms_pkg::entry_t            cur_i,
  input  logic                         in_valid_i,
  input  logic [AW-1:0]                in_idx_i,
  input  canms_pkg::entry_t            cand_i,
  output logic                         hit_valid_o,
  output logic [AW-1:0]                hit_idx_o,
  output logic                         busy_o
);

  // doubled edge coordinates, signed since 2x-w can go negative
  logic signed [18:0] la, ra, lb, rb, ta, ba, tb, bb;
  logic signed [18:0] lmax, rmin, tmax, bmin;
  logic signed [19:0] iw_s, ih_s;
  logic [16:0] iw, ih;

  logic          v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0] i1_q, i2_q, i3_q, i4_q;
  logic          s1_q, s2_q, s3_q, hit4_q;
  logic [16:0]   iw1_q, ih1_q;
  logic [15:0]   wb1_q, hb1_q;
  logic [31:0]   areaa_q, areab2_q;
  logic [33:0]   inter2_q, inter3_q;
  logic [34:0]   uni3_q;
  logic [43:0]   rhs;
  logic [41:0]   lhs;

  always_comb begin
    la = $signed({2'b00, cur_i.x, 1'b0}) - $signed({3'b000, cur_i.w});
    ra = $signed({2'b00, cur_i.x, 1'b0}) + $signed({3'b000, cur_i.w});
    lb = $signed({2'b00, cand_i.x, 1'b0}) - $signed({3'b000, cand_i.w});
    rb = $signed({2'b00, cand_i.x, 1'b0}) + $signed({3'b000, cand_i.w});
    ta = $signed({2'b00, cur_i.y, 1'b0}) - $signed({3'b000, cur_i.h});
    ba = $signed({2'b00, cur_i.y, 1'b0}) + $signed({3'b000, cur_i.h});
    tb = $signed({2'b00, cand_i.y, 1'b0}) - $signed({3'b000, cand_i.h});
    bb = $signed({2'b00, cand_i.y, 1'b0}) + $signed({3'b000, cand_i.h});
    lmax = (la > lb) ? la : lb;
    rmin = (ra < rb) ? ra : rb;
    tmax = (ta > tb) ? ta : tb;
    bmin = (ba < bb) ? ba : bb;
    iw_s = {rmin[18], rmin} - {lmax[18], lmax};
    ih_s = {bmin[18], bmin} - {tmax[18], tmax};
    // overlap never exceeds twice the smaller size, so 17 bits hold it
    iw = iw_s[19] ? 17'd0 : iw_s[16:0];
    ih = ih_s[19] ? 17'd0 : ih_s[16:0];
  end

  assign rhs = {26'd0, thr_i} * {9'd0, uni3_q};
  assign lhs = {inter3_q, 8'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    areaa_q  <= cur_i.w * cur_i.h;
    iw1_q    <= iw;
    ih1_q    <= ih;
    wb1_q    <= cand_i.w;
    hb1_q    <= cand_i.h;
    s1_q     <= (cand_i.cls == cur_i.cls);
    i1_q     <= in_idx_i;
    inter2_q <= iw1_q * ih1_q;
    areab2_q <= wb1_q * hb1_q;
    s2_q     <= s1_q;
    i2_q     <= i1_q;
    inter3_q <= inter2_q;
    uni3_q   <= ({1'b0, areaa_q, 2'b00} + {1'b0, areab2_q, 2'b00}) - {1'b0, inter2_q};
    s3_q     <= s2_q;
    i3_q     <= i2_q;
    hit4_q   <= s3_q && (uni3_q != 35'd0) && ({2'b00, lhs} > rhs);
    i4_q     <= i3_q;
  end

  assign hit_valid_o = v4_q & hit4_q;
  assign hit_idx_o   = i4_q;
  assign busy_o      = v1_q | v2_q | v3_q | v4_q;

endmodule

/* src/canms_back.sv */
// Engine: sorted box store, greedy suppression sequencer and result register.
// Depends on canms_pkg, canms_iou and class_aware_box_nms_defines.svh.
`include "class_aware_box_nms_defines.svh"
module canms_back #(
  parameter int unsigned MaxBoxes = canms_pkg::MAX_BOXES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [canms_pkg::THR_W-1:0]  thr_i,
  input  logic                         q_valid_i,
  input  canms_pkg::item_t             q_item_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output canms_pkg::res_t              out_res_o
);

  localparam int unsigned AW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned CW = $clog2(MaxBoxes + 1);
  localparam int unsigned KW = canms_pkg::KW;
  localparam logic [CW-1:0] FULL  = CW'(MaxBoxes);
  localparam logic [KW-1:0] LIMIT = KW'(canms_pkg::RESULT_LIMIT);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SHIFT = 4'd1;
  localparam logic [3:0] ST_PUT   = 4'd2;
  localparam logic [3:0] ST_RDI   = 4'd3;
  localparam logic [3:0] ST_CHKI  = 4'd4;
  localparam logic [3:0] ST_EMIT  = 4'd5;
  localparam logic [3:0] ST_JRUN  = 4'd6;
  localparam logic [3:0] ST_DRAIN = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;

  canms_pkg::entry_t mem [MaxBoxes];
  logic              mark_mem [MaxBoxes];
  canms_pkg::entry_t rd_q;
  logic              mark_q;

  logic [3:0]        st_q, st_d;
  logic [CW-1:0]     cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [AW-1:0]     idx_q, idx_d, rj_q, rj_d;
  logic [KW-1:0]     k_q, k_d;
  logic              ovf_q, ovf_d, pend_v_q, pend_v_d, rv_q, rv_d;
  canms_pkg::item_t  ins_q, ins_d;
  canms_pkg::entry_t cur_q, cur_d, pend_q, pend_d;
  logic              out_v_q;
  canms_pkg::res_t   out_q, push_res;

  logic              push, out_free, we, mwe, mdata;
  logic [AW-1:0]     raddr, waddr, maddr;
  canms_pkg::entry_t wdata;
  logic              hit_v, iou_busy;
  logic [AW-1:0]     hit_idx;

  assign out_free = !out_v_q || out_ready_i;

  canms_iou #(.AW(AW)) u_iou (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_i),
    .cur_i       (cur_q),
    .in_valid_i  (rv_q),
    .in_idx_i    (rj_q),
    .cand_i      (rd_q),
    .hit_valid_o (hit_v),
    .hit_idx_o   (hit_idx),
    .busy_o      (iou_busy)
  );

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    idx_d    = idx_q;
    rj_d     = rj_q;
    k_d      = k_q;
    ovf_d    = ovf_q;
    pend_v_d = pend_v_q;
    rv_d     = 1'b0;
    ins_d    = ins_q;
    cur_d    = cur_q;
    pend_d   = pend_q;
    q_pop_o  = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = rd_q;
    push     = 1'b0;
    push_res = '{box: pend_q, last: 1'b0, ovf: ovf_q};

    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ins_d   = q_item_i;
          if (cnt_q < FULL) begin
            idx_d = cnt_q[AW-1:0];
            raddr = cnt_q[AW-1:0] - AW'(1);
            st_d  = (cnt_q == '0) ? ST_PUT : ST_SHIFT;
          end else begin
            // store full: box dropped
            ovf_d = 1'b1;
            if (q_item_i.last_box) begin
              i_d      = '0;
              k_d      = '0;
              pend_v_d = 1'b0;
              st_d     = ST_RDI;
            end
          end
        end
      end
      ST_SHIFT: begin
        // walk down from the tail, moving lower scores up one slot
        if (rd_q.score < ins_q.box.score) begin
          we    = 1'b1;
          waddr = idx_q;
          wdata = rd_q;
          idx_d = idx_q - AW'(1);
          raddr = idx_q - AW'(2);
          if (idx_q == AW'(1)) begin
            st_d = ST_PUT;
          end
        end else begin
          st_d = ST_PUT;
        end
      end
      ST_PUT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = ins_q.box;
        cnt_d = cnt_q + CW'(1);
        if (ins_q.last_box) begin
          i_d      = '0;
          k_d      = '0;
          pend_v_d = 1'b0;
          st_d     = ST_RDI;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_RDI: begin
        if (i_q == cnt_q) begin
          st_d = ST_FLUSH;
        end else begin
          raddr = i_q[AW-1:0];
          st_d  = ST_CHKI;
        end
      end
      ST_CHKI: begin
        if (mark_q) begin
          i_d  = i_q + CW'(1);
          st_d = ST_RDI;
        end else begin
          cur_d = rd_q;
          j_d   = i_q + CW'(1);
          st_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // one kept box is held back so the final one can carry last
        if (k_q >= LIMIT) begin
          st_d = ST_JRUN;
        end else if (!pend_v_q || out_free) begin
          push     = pend_v_q;
          pend_d   = cur_q;
          pend_v_d = 1'b1;
          k_d      = k_q + KW'(1);
          st_d     = ST_JRUN;
        end
      end
      ST_JRUN: begin
        if (j_q < cnt_q) begin
          raddr = j_q[AW-1:0];
          rv_d  = 1'b1;
          rj_d  = j_q[AW-1:0];
          j_d   = j_q + CW'(1);
        end else begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rv_q && !iou_busy) begin
          i_d  = i_q + CW'(1);
          st_d = ST_RDI;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          push          = pend_v_q;
          push_res.last = 1'b1;
          pend_v_d      = 1'b0;
          cnt_d         = '0;
          ovf_d         = 1'b0;
          st_d          = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // every slot below the count is rewritten during loading, which clears its mark
  assign mwe   = we | hit_v;
  assign maddr = hit_v ? hit_idx : waddr;
  assign mdata = hit_v;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (mwe) begin
      mark_mem[maddr] <= mdata;
    end
    rd_q   <= mem[raddr];
    mark_q <= mark_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      rv_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      rv_q     <= rv_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    rj_q   <= rj_d;
    ins_q  <= ins_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
    if (push) begin
      out_q <= push_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  `CANMS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= FULL, "box count beyond store size")
  `CANMS_ASSERT(a_ovf_full, clk_i, rst_ni, ovf_q |-> (cnt_q == FULL), "overflow with room left")
  `CANMS_ASSERT(a_k_bound, clk_i, rst_ni, k_q <= LIMIT, "kept count beyond result limit")
  `CANMS_NEVER(a_shift_idx, clk_i, rst_ni, (st_q == ST_SHIFT) && (idx_q == '0), "shift at slot 0")
  `CANMS_NEVER(a_rdi_quiet, clk_i, rst_ni, (st_q == ST_RDI) && (iou_busy || rv_q), "mark read races a pending mark write")

endmodule
